FILE: design/assert_macros.svh
// Assertion macros for the checker file of this block.
// Clock, both sides of each check and, where the macro takes one, reset are passed in by the user.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, switched off while reset is low.
`define TPVT_ASSERT_IMP(lbl, ck, rstn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// Next-cycle implication, switched off while reset is low.
`define TPVT_ASSERT_NXT(lbl, ck, rstn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

// Next-cycle implication that also holds across reset.
`define TPVT_ASSERT_RST(lbl, ck, ante, cons) \
  lbl: assert property (@(posedge ck) (ante) |=> (cons)) \
    else $error("reset check failed");

`endif

FILE: design/tpvt_pkg.sv
// Shared types, constants and helpers of the text plane vertex transform.
// No dependencies; every module file imports this package.
`default_nettype none

package tpvt_pkg;

  localparam int COORD_BITS = 16;

  localparam int Q_DEPTH = 4;
  localparam int Q_AW    = $clog2(Q_DEPTH);

  localparam int CFG_AW = 6;

  localparam logic [2:0] REG_FACE    = 3'd0;
  localparam logic [2:0] REG_UP      = 3'd1;
  localparam logic [2:0] REG_ANCHOR  = 3'd2;
  localparam logic [2:0] REG_HWORLD  = 3'd3;
  localparam logic [2:0] REG_HPIXELS = 3'd4;

  localparam logic [15:0] HWORLD_RESET  = 16'd256;
  localparam logic [15:0] HPIXELS_RESET = 16'd256;

  localparam logic [1:0] ERR_NONE      = 2'd0;
  localparam logic [1:0] ERR_ZERO_FACE = 2'd1;
  localparam logic [1:0] ERR_ZERO_UP   = 2'd2;
  localparam logic [1:0] ERR_COLLINEAR = 2'd3;

  localparam logic signed [32:0] SAT_HI = 33'((64'sd1 <<< (COORD_BITS - 1)) - 64'sd1);
  localparam logic signed [32:0] SAT_LO = 33'(-(64'sd1 <<< (COORD_BITS - 1)));

  typedef struct packed {
    logic signed [15:0] local_x;
    logic signed [15:0] local_y;
    logic [15:0]        tex_u;
    logic [15:0]        tex_v;
    logic               last_vertex;
  } in_item_t;

  typedef struct packed {
    logic signed [15:0] world_x;
    logic signed [15:0] world_y;
    logic signed [15:0] world_z;
    logic [15:0]        tex_u_out;
    logic [15:0]        tex_v_out;
    logic [15:0]        world_scale;
    logic [1:0]         basis_error;
    logic               last_out;
  } out_item_t;

  typedef struct packed {
    in_item_t item;
    logic     first;
  } q_item_t;

  typedef struct packed {
    logic [47:0] face_vector;
    logic [47:0] up_vector;
    logic [47:0] anchor_point;
    logic [15:0] world_height;
    logic [15:0] height_pixels;
  } cfg_t;

  typedef struct packed {
    logic [2:0][15:0] right_axis;
    logic [2:0][15:0] up_axis;
    logic [15:0]      scale;
    logic [1:0]       status;
  } basis_t;

  typedef enum logic [3:0] {
    BS_IDLE, BS_SCALE, BS_DOT, BS_WVEC, BS_WCHK, BS_NLOAD, BS_NSHIFT,
    BS_NLEN, BS_NSQRT, BS_NDLOAD, BS_NDIV, BS_CPROD, BS_CRND, BS_DONE
  } bs_state_t;

  // One signed 16-bit component of a packed x,y,z vector.
  function automatic logic signed [15:0] comp3(input logic [47:0] v, input logic [1:0] k);
    logic signed [15:0] c;
    unique case (k)
      2'd0:    c = v[15:0];
      2'd1:    c = v[31:16];
      default: c = v[47:32];
    endcase
    return c;
  endfunction

  // Cyclic successor of a component index.
  function automatic logic [1:0] next3(input logic [1:0] k);
    logic [1:0] n;
    unique case (k)
      2'd0:    n = 2'd1;
      2'd1:    n = 2'd2;
      default: n = 2'd0;
    endcase
    return n;
  endfunction

endpackage

`default_nettype wire

FILE: design/tpvt_front.sv
// Front end: accepts vertex beats, marks the first beat of each list and queues them.
// Depends on tpvt_pkg.
`default_nettype none

module tpvt_front import tpvt_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_ready,
  input  wire in_item_t in_data,
  output logic          head_valid,
  output q_item_t       head,
  input  wire logic     pop
);

  q_item_t         q_r [Q_DEPTH];
  logic [Q_AW-1:0] wp_r, rp_r;
  logic [Q_AW:0]   cnt_r;
  logic            first_r;
  logic            push;

  assign in_ready   = (cnt_r != (Q_AW+1)'(Q_DEPTH));
  assign push       = in_valid && in_ready;
  assign head_valid = (cnt_r != '0);
  assign head       = q_r[rp_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r    <= '0;
      rp_r    <= '0;
      cnt_r   <= '0;
      first_r <= 1'b1;
    end else begin
      if (push) begin
        wp_r    <= wp_r + 1'b1;
        first_r <= in_data.last_vertex;
      end
      if (pop) begin
        rp_r <= rp_r + 1'b1;
      end
      priority if (push && !pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (pop && !push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wp_r] <= '{item: in_data, first: first_r};
    end
  end

endmodule

`default_nettype wire

FILE: design/tpvt_basis.sv
// Basis engine: sequencer that builds the scale, the unit up axis and the right axis.
// One shared shift, square-root and divide datapath, one step per cycle. Depends on tpvt_pkg.
`default_nettype none

module tpvt_basis import tpvt_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic start,
  input  wire cfg_t cfg,
  output logic      busy,
  output logic      done,
  output basis_t    basis
);

  bs_state_t state_r, state_nxt;
  logic [4:0]  cnt_r, cnt_nxt;
  logic [1:0]  idx_r, idx_nxt;
  logic        pass_r, pass_nxt;
  logic [24:0] sd_r, sd_nxt, sq_r, sq_nxt;
  logic [15:0] srem_r, srem_nxt;
  logic signed [33:0] ff_r, ff_nxt, uf_r, uf_nxt;
  logic signed [49:0] w_r [3], w_nxt [3];
  logic [49:0] mag_r [3], mag_nxt [3];
  logic        neg_r [3], neg_nxt [3];
  logic [42:0] len2_r, len2_nxt, sv_r, sv_nxt, sr_r, sr_nxt, sbit_r, sbit_nxt;
  logic [20:0] drem_r, drem_nxt;
  logic [13:0] ddv_r, ddv_nxt, dq_r, dq_nxt;
  logic signed [15:0] n_r [3], n_nxt [3], uh_r [3], uh_nxt [3], rt_r [3], rt_nxt [3];
  logic signed [31:0] cp1_r, cp1_nxt, cp2_r, cp2_nxt;
  logic [15:0] scale_r, scale_nxt;
  logic [1:0]  status_r, status_nxt;

  always_comb begin
    logic [16:0] st;
    logic        qb;
    logic signed [15:0] fk, uk;
    logic signed [31:0] pa, pb;
    logic signed [49:0] wp1, wp2, src;
    logic        big, tiny;
    logic [39:0] sqv;
    logic [42:0] trial;
    logic [33:0] dd;
    logic [21:0] dt;
    logic [21:0] ln;
    logic signed [15:0] qs;
    logic [1:0]  i1, i2;
    logic signed [31:0] cd;
    logic [31:0] cm, cr;

    state_nxt  = state_r;
    cnt_nxt    = cnt_r;
    idx_nxt    = idx_r;
    pass_nxt   = pass_r;
    sd_nxt     = sd_r;
    sq_nxt     = sq_r;
    srem_nxt   = srem_r;
    ff_nxt     = ff_r;
    uf_nxt     = uf_r;
    w_nxt      = w_r;
    mag_nxt    = mag_r;
    neg_nxt    = neg_r;
    len2_nxt   = len2_r;
    sv_nxt     = sv_r;
    sr_nxt     = sr_r;
    sbit_nxt   = sbit_r;
    drem_nxt   = drem_r;
    ddv_nxt    = ddv_r;
    dq_nxt     = dq_r;
    n_nxt      = n_r;
    uh_nxt     = uh_r;
    rt_nxt     = rt_r;
    cp1_nxt    = cp1_r;
    cp2_nxt    = cp2_r;
    scale_nxt  = scale_r;
    status_nxt = status_r;

    fk  = comp3(cfg.face_vector, idx_r);
    uk  = comp3(cfg.up_vector, idx_r);
    st  = {srem_r, sd_r[24]};
    qb  = (st >= {1'b0, cfg.height_pixels});
    pa  = fk * fk;
    pb  = uk * fk;
    wp1 = uk * ff_r;
    wp2 = uf_r * fk;
    big  = (mag_r[0][49:20] != '0) || (mag_r[1][49:20] != '0) || (mag_r[2][49:20] != '0);
    tiny = (mag_r[0][49:19] == '0) && (mag_r[1][49:19] == '0) && (mag_r[2][49:19] == '0);
    sqv   = mag_r[idx_r][19:0] * mag_r[idx_r][19:0];
    trial = sr_r + sbit_r;
    dd    = {1'b0, mag_r[idx_r][19:0], 13'd0} + 34'(sr_r[20:1]);
    dt    = {drem_r, ddv_r[13]};
    ln    = {1'b0, sr_r[20:0]};
    i1    = next3(idx_r);
    i2    = next3(i1);
    cd    = cp1_r - cp2_r;
    cm    = cd[31] ? 32'(-cd) : 32'(cd);
    cr    = (cm + 32'd4096) >> 13;
    src   = '0;
    qs    = '0;

    unique case (state_r)
      BS_IDLE: begin
        if (start) begin
          sd_nxt     = 25'({cfg.world_height, 8'h00}) + 25'(cfg.height_pixels[15:1]);
          sq_nxt     = '0;
          srem_nxt   = '0;
          cnt_nxt    = '0;
          status_nxt = ERR_NONE;
          state_nxt  = BS_SCALE;
        end
      end
      BS_SCALE: begin
        // Restoring division, one quotient bit a cycle.
        srem_nxt = qb ? 16'(st - {1'b0, cfg.height_pixels}) : st[15:0];
        sd_nxt   = {sd_r[23:0], 1'b0};
        sq_nxt   = {sq_r[23:0], qb};
        cnt_nxt  = cnt_r + 1'b1;
        if (cnt_r == 5'd24) begin
          scale_nxt = ((cfg.height_pixels == '0) || (sq_nxt[24:16] != '0)) ? 16'hFFFF
                      : sq_nxt[15:0];
          ff_nxt  = '0;
          uf_nxt  = '0;
          idx_nxt = '0;
          priority if (cfg.face_vector == '0) begin
            status_nxt = ERR_ZERO_FACE;
            state_nxt  = BS_DONE;
          end else if (cfg.up_vector == '0) begin
            status_nxt = ERR_ZERO_UP;
            state_nxt  = BS_DONE;
          end else begin
            state_nxt = BS_DOT;
          end
        end
      end
      BS_DOT: begin
        ff_nxt  = ff_r + 34'(pa);
        uf_nxt  = uf_r + 34'(pb);
        idx_nxt = next3(idx_r);
        if (idx_r == 2'd2) begin
          state_nxt = BS_WVEC;
        end
      end
      BS_WVEC: begin
        w_nxt[idx_r] = wp1 - wp2;
        idx_nxt      = next3(idx_r);
        if (idx_r == 2'd2) begin
          state_nxt = BS_WCHK;
        end
      end
      BS_WCHK: begin
        if ((w_r[0] == '0) && (w_r[1] == '0) && (w_r[2] == '0)) begin
          status_nxt = ERR_COLLINEAR;
          state_nxt  = BS_DONE;
        end else begin
          pass_nxt  = 1'b0;
          state_nxt = BS_NLOAD;
        end
      end
      BS_NLOAD: begin
        for (int k = 0; k < 3; k++) begin
          src        = pass_r ? w_r[k] : 50'(comp3(cfg.face_vector, 2'(k)));
          neg_nxt[k] = src[49];
          mag_nxt[k] = src[49] ? 50'(-src) : 50'(src);
        end
        state_nxt = BS_NSHIFT;
      end
      BS_NSHIFT: begin
        // Bring the largest magnitude into [2^19, 2^20), one bit a cycle.
        priority if (big) begin
          for (int k = 0; k < 3; k++) mag_nxt[k] = mag_r[k] >> 1;
        end else if (tiny) begin
          for (int k = 0; k < 3; k++) mag_nxt[k] = mag_r[k] << 1;
        end else begin
          len2_nxt  = '0;
          idx_nxt   = '0;
          state_nxt = BS_NLEN;
        end
      end
      BS_NLEN: begin
        len2_nxt = len2_r + 43'(sqv);
        idx_nxt  = next3(idx_r);
        if (idx_r == 2'd2) begin
          sv_nxt    = len2_nxt;
          sr_nxt    = '0;
          sbit_nxt  = 43'(1) << 42;
          state_nxt = BS_NSQRT;
        end
      end
      BS_NSQRT: begin
        if (sv_r >= trial) begin
          sv_nxt = sv_r - trial;
          sr_nxt = (sr_r >> 1) + sbit_r;
        end else begin
          sr_nxt = sr_r >> 1;
        end
        sbit_nxt = sbit_r >> 2;
        if (sbit_r == 43'd1) begin
          state_nxt = BS_NDLOAD;
        end
      end
      BS_NDLOAD: begin
        drem_nxt  = {1'b0, dd[33:14]};
        ddv_nxt   = dd[13:0];
        dq_nxt    = '0;
        cnt_nxt   = '0;
        state_nxt = BS_NDIV;
      end
      BS_NDIV: begin
        drem_nxt = (dt >= ln) ? 21'(dt - ln) : dt[20:0];
        ddv_nxt  = {ddv_r[12:0], 1'b0};
        dq_nxt   = {dq_r[12:0], (dt >= ln)};
        cnt_nxt  = cnt_r + 1'b1;
        if (cnt_r == 5'd13) begin
          qs = neg_r[idx_r] ? -$signed({2'b00, dq_nxt}) : $signed({2'b00, dq_nxt});
          if (pass_r) begin
            uh_nxt[idx_r] = qs;
          end else begin
            n_nxt[idx_r] = qs;
          end
          idx_nxt = next3(idx_r);
          priority if (idx_r != 2'd2) begin
            state_nxt = BS_NDLOAD;
          end else if (!pass_r) begin
            pass_nxt  = 1'b1;
            state_nxt = BS_NLOAD;
          end else begin
            state_nxt = BS_CPROD;
          end
        end
      end
      BS_CPROD: begin
        cp1_nxt   = uh_r[i1] * n_r[i2];
        cp2_nxt   = uh_r[i2] * n_r[i1];
        state_nxt = BS_CRND;
      end
      BS_CRND: begin
        rt_nxt[idx_r] = cd[31] ? -$signed(cr[15:0]) : $signed(cr[15:0]);
        idx_nxt       = next3(idx_r);
        state_nxt     = (idx_r == 2'd2) ? BS_DONE : BS_CPROD;
      end
      BS_DONE: begin
        state_nxt = BS_IDLE;
      end
      default: begin
        state_nxt = BS_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= BS_IDLE;
      status_r <= ERR_NONE;
    end else begin
      state_r  <= state_nxt;
      status_r <= status_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cnt_r   <= cnt_nxt;
    idx_r   <= idx_nxt;
    pass_r  <= pass_nxt;
    sd_r    <= sd_nxt;
    sq_r    <= sq_nxt;
    srem_r  <= srem_nxt;
    ff_r    <= ff_nxt;
    uf_r    <= uf_nxt;
    w_r     <= w_nxt;
    mag_r   <= mag_nxt;
    neg_r   <= neg_nxt;
    len2_r  <= len2_nxt;
    sv_r    <= sv_nxt;
    sr_r    <= sr_nxt;
    sbit_r  <= sbit_nxt;
    drem_r  <= drem_nxt;
    ddv_r   <= ddv_nxt;
    dq_r    <= dq_nxt;
    n_r     <= n_nxt;
    uh_r    <= uh_nxt;
    rt_r    <= rt_nxt;
    cp1_r   <= cp1_nxt;
    cp2_r   <= cp2_nxt;
    scale_r <= scale_nxt;
  end

  assign busy = (state_r != BS_IDLE);
  assign done = (state_r == BS_DONE);

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      basis.right_axis[k] = rt_r[k];
      basis.up_axis[k]    = uh_r[k];
    end
    basis.scale  = scale_r;
    basis.status = status_r;
  end

endmodule

`default_nettype wire

FILE: design/tpvt_back.sv
// Back end: starts the basis engine at a new list and runs the four-stage vertex pipeline.
// Depends on tpvt_pkg and tpvt_basis.
`default_nettype none

module tpvt_back import tpvt_pkg::*; (
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    head_valid,
  input  wire q_item_t head,
  output logic         pop,
  input  wire cfg_t    cfg,
  output logic         out_valid,
  input  wire logic    out_ready,
  output out_item_t    out_data
);

  basis_t bas;
  logic   eng_busy, eng_done, eng_start;
  logic   have_r, adv, pipe_empty;

  logic     v1_r, v2_r, v3_r, ov_r;
  in_item_t it1_r, it2_r, it3_r;
  logic signed [33:0] sx1_r, sy1_r;
  logic signed [49:0] pr2_r [3], pu2_r [3];
  logic signed [50:0] sum3_r [3];
  out_item_t od_r, od_nxt;

  tpvt_basis u_basis (
    .clk   (clk),
    .rst_n (rst_n),
    .start (eng_start),
    .cfg   (cfg),
    .busy  (eng_busy),
    .done  (eng_done),
    .basis (bas)
  );

  assign adv        = !ov_r || out_ready;
  assign pipe_empty = !v1_r && !v2_r && !v3_r;
  // A new basis is built only once the previous list has left the arithmetic stages.
  assign eng_start  = head_valid && head.first && !have_r && pipe_empty && !eng_busy;
  assign pop        = adv && head_valid && (!head.first || have_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      have_r <= 1'b0;
      v1_r   <= 1'b0;
      v2_r   <= 1'b0;
      v3_r   <= 1'b0;
      ov_r   <= 1'b0;
    end else begin
      priority if (pop && head.first) begin
        have_r <= 1'b0;
      end else if (eng_done) begin
        have_r <= 1'b1;
      end
      if (adv) begin
        v1_r <= pop;
        v2_r <= v1_r;
        v3_r <= v2_r;
        ov_r <= v3_r;
      end
    end
  end

  always_comb begin
    logic signed [50:0] s;
    logic [50:0] m;
    logic [29:0] rq;
    logic signed [32:0] tot;
    od_nxt.tex_u_out   = it3_r.tex_u;
    od_nxt.tex_v_out   = it3_r.tex_v;
    od_nxt.last_out    = it3_r.last_vertex;
    od_nxt.basis_error = bas.status;
    od_nxt.world_scale = (bas.status == ERR_NONE) ? bas.scale : '0;
    od_nxt.world_x     = '0;
    od_nxt.world_y     = '0;
    od_nxt.world_z     = '0;
    for (int i = 0; i < 3; i++) begin
      s   = sum3_r[i];
      m   = s[50] ? 51'(-s) : 51'(s);
      rq  = 30'((m + 51'(1 << 20)) >> 21);
      tot = (s[50] ? -$signed({3'b000, rq}) : $signed({3'b000, rq}))
            + 33'(comp3(cfg.anchor_point, 2'(i)));
      if (tot > SAT_HI) tot = SAT_HI;
      if (tot < SAT_LO) tot = SAT_LO;
      if (bas.status == ERR_NONE) begin
        unique case (i)
          0:       od_nxt.world_x = tot[15:0];
          1:       od_nxt.world_y = tot[15:0];
          default: od_nxt.world_z = tot[15:0];
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      it1_r <= head.item;
      sx1_r <= head.item.local_x * $signed({1'b0, bas.scale});
      sy1_r <= (-$signed({head.item.local_y[15], head.item.local_y}))
               * $signed({1'b0, bas.scale});
      it2_r <= it1_r;
      for (int i = 0; i < 3; i++) begin
        pr2_r[i]  <= $signed(bas.right_axis[i]) * sx1_r;
        pu2_r[i]  <= $signed(bas.up_axis[i]) * sy1_r;
        sum3_r[i] <= 51'(pr2_r[i]) + 51'(pu2_r[i]);
      end
      it3_r <= it2_r;
      od_r  <= od_nxt;
    end
  end

  assign out_valid = ov_r;
  assign out_data  = od_r;

endmodule

`default_nettype wire

FILE: design/text_plane_vertex_transform.sv
// Text plane vertex transform: top level with the register port, front end and back end.
// Depends on tpvt_pkg, tpvt_front and tpvt_back.
//
// Use: program face_vector, up_vector, anchor_point, world_height and
// height_pixels over the register port (byte addresses 0x00, 0x08, 0x10,
// 0x18 and 0x20, 64-bit data) while the block is idle. Then send glyph
// vertices on the in_ channel, one beat per vertex, with last_vertex set on
// the final vertex of each list. Every input beat gives exactly one output
// beat, in order, carrying the world position, the texture coordinates,
// the scale and the basis error code of its list.
// At the first vertex of a list the back end waits until earlier vertices
// have left its arithmetic stages and then builds the basis with a shared
// shift, square-root and divide sequencer. After that the pipeline takes
// one vertex per cycle unless a held output beat stalls it, and each result
// passes the queue, the three arithmetic stages and the output register.
// Reset clears the queue and the pipeline and restores the register reset
// values; the first vertex after reset starts a new list. When the receiver
// holds out_ready low the output register keeps its beat, the pipeline
// stops, and the four-entry input queue keeps taking beats until it fills.
`default_nettype none

module text_plane_vertex_transform import tpvt_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire in_item_t          in_data,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output out_item_t              out_data,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [CFG_AW-1:0] paddr,
  input  wire logic [63:0]       pwdata,
  output logic [63:0]            prdata,
  output logic                   pready
);

  logic [47:0] face_r, up_r, anchor_r;
  logic [15:0] hworld_r, hpix_r;
  cfg_t        cfg;
  q_item_t     head;
  logic        head_valid, pop;

  assign pready = 1'b1;

  // Register writes complete in the access phase; pready is always high.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      face_r   <= '0;
      up_r     <= '0;
      anchor_r <= '0;
      hworld_r <= HWORLD_RESET;
      hpix_r   <= HPIXELS_RESET;
    end else if (psel && penable && pwrite) begin
      unique case (paddr[5:3])
        REG_FACE:    face_r   <= pwdata[47:0];
        REG_UP:      up_r     <= pwdata[47:0];
        REG_ANCHOR:  anchor_r <= pwdata[47:0];
        REG_HWORLD:  hworld_r <= pwdata[15:0];
        REG_HPIXELS: hpix_r   <= pwdata[15:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    unique case (paddr[5:3])
      REG_FACE:    prdata = 64'(face_r);
      REG_UP:      prdata = 64'(up_r);
      REG_ANCHOR:  prdata = 64'(anchor_r);
      REG_HWORLD:  prdata = 64'(hworld_r);
      REG_HPIXELS: prdata = 64'(hpix_r);
      default:     prdata = '0;
    endcase
  end

  assign cfg = '{face_vector: face_r, up_vector: up_r, anchor_point: anchor_r,
                 world_height: hworld_r, height_pixels: hpix_r};

  tpvt_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop)
  );

  tpvt_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop),
    .cfg        (cfg),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data)
  );

endmodule

`default_nettype wire

FILE: design/tpvt_checker.sv
// Port-level checker for the text plane vertex transform, bound to the top level.
// Depends on tpvt_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module tpvt_checker import tpvt_pkg::*; (
  input wire logic      clk,
  input wire logic      rst_n,
  input wire logic      in_ready,
  input wire logic      out_valid,
  input wire logic      out_ready,
  input wire out_item_t out_data
);

  // A stalled result beat holds.
  `TPVT_ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_data))

  // A list with a bad basis delivers no position and no scale.
  `TPVT_ASSERT_IMP(a_err_zero, clk, rst_n, out_valid && (out_data.basis_error != ERR_NONE), (out_data.world_x == 16'sd0) && (out_data.world_y == 16'sd0) && (out_data.world_z == 16'sd0) && (out_data.world_scale == 16'd0))

  // Reset leaves the queue empty and no result pending.
  `TPVT_ASSERT_RST(a_reset_clean, clk, !rst_n, in_ready && !out_valid)

endmodule

bind text_plane_vertex_transform tpvt_checker u_tpvt_checker (.*);

`default_nettype wire

FILE: bench/testbench.sv
// Self-checking bench for the text plane vertex transform: register writes, a clocked
// driver for vertex beats and a monitor that checks results against an in-bench model.
// Depends on tpvt_pkg and text_plane_vertex_transform.
`timescale 1ns / 1ps

module testbench import tpvt_pkg::*; ();

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  in_item_t    in_data;
  logic        out_valid;
  logic        out_ready;
  out_item_t   out_data;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [CFG_AW-1:0] paddr;
  logic [63:0] pwdata;
  logic [63:0] prdata;
  logic        pready;

  text_plane_vertex_transform DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  // Vertices waiting to be driven, and world positions waiting to come out.
  in_item_t  vertex_q[$];
  out_item_t world_q[$];

  // Shadow copy of the registers and of the latched basis.
  logic [47:0] face_reg, up_reg, anchor_reg;
  logic [15:0] hworld_reg, hpix_reg;
  longint      right_ax[3], up_ax[3];
  longint      scale_lat;
  logic [1:0]  status_lat;
  bit          basis_valid;

  int  mismatches;
  bit  quiet;          // no idling on either side in the closing stretch
  int  hold_asks, hold_served;
  bit  in_took;
  int  idle_cycles;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------------
  // Model arithmetic. Vectors are three signed 16-bit components packed
  // x in the low bits, z in the high bits.
  // ---------------------------------------------------------------------
  function automatic longint comp_of(logic [47:0] v, int k);
    logic signed [15:0] c;
    c = v[16*k +: 16];
    return longint'(c);
  endfunction

  // Divide by 2^s, rounding to nearest with ties away from zero.
  function automatic longint round_away(longint v, int s);
    longint m;
    m = v < 0 ? -v : v;
    m = (m + (64'sd1 <<< (s - 1))) >>> s;
    return v < 0 ? -m : m;
  endfunction

  function automatic longint floor_sqrt(longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return longint'(r);
  endfunction

  // Unit vector in Q2.13. The magnitudes are first brought into [2^19, 2^20)
  // so that the square root keeps a fixed precision.
  task automatic unit_vector(input longint v[3], output longint o[3]);
    longint m[3];
    longint mx, len;
    mx = 0;
    for (int i = 0; i < 3; i++) begin
      m[i] = v[i] < 0 ? -v[i] : v[i];
      if (m[i] > mx) mx = m[i];
    end
    while (mx >= (64'sd1 <<< 20)) begin
      for (int i = 0; i < 3; i++) m[i] = m[i] >>> 1;
      mx = mx >>> 1;
    end
    while (mx < (64'sd1 <<< 19)) begin
      for (int i = 0; i < 3; i++) m[i] = m[i] <<< 1;
      mx = mx <<< 1;
    end
    len = floor_sqrt(m[0] * m[0] + m[1] * m[1] + m[2] * m[2]);
    if (len == 0) len = 1;
    for (int i = 0; i < 3; i++) begin
      o[i] = (m[i] * 8192 + len / 2) / len;
      if (v[i] < 0) o[i] = -o[i];
    end
  endtask

  // Latch the basis and scale from the current register values.
  task automatic latch_basis();
    longint f[3], u[3], w[3], n[3], uh[3];
    longint ff, uf, q;
    if (hpix_reg == 0) begin
      scale_lat = 65535;
    end else begin
      q = (longint'(hworld_reg) * 256 + longint'(hpix_reg) / 2) / longint'(hpix_reg);
      scale_lat = q > 65535 ? 65535 : q;
    end
    for (int i = 0; i < 3; i++) begin
      right_ax[i] = 0;
      up_ax[i] = 0;
      f[i] = comp_of(face_reg, i);
      u[i] = comp_of(up_reg, i);
    end
    if (f[0] == 0 && f[1] == 0 && f[2] == 0) begin
      status_lat = ERR_ZERO_FACE;
    end else if (u[0] == 0 && u[1] == 0 && u[2] == 0) begin
      status_lat = ERR_ZERO_UP;
    end else begin
      // Gram-Schmidt on exact integers: w = up*(f.f) - (up.f)*f.
      ff = f[0] * f[0] + f[1] * f[1] + f[2] * f[2];
      uf = u[0] * f[0] + u[1] * f[1] + u[2] * f[2];
      for (int i = 0; i < 3; i++) w[i] = u[i] * ff - uf * f[i];
      if (w[0] == 0 && w[1] == 0 && w[2] == 0) begin
        status_lat = ERR_COLLINEAR;
      end else begin
        unit_vector(f, n);
        unit_vector(w, uh);
        right_ax[0] = round_away(uh[1] * n[2] - uh[2] * n[1], 13);
        right_ax[1] = round_away(uh[2] * n[0] - uh[0] * n[2], 13);
        right_ax[2] = round_away(uh[0] * n[1] - uh[1] * n[0], 13);
        for (int i = 0; i < 3; i++) begin
          // The stored axes are 16-bit registers.
          right_ax[i] = longint'(signed'(right_ax[i][15:0]));
          up_ax[i] = longint'(signed'(uh[i][15:0]));
        end
        status_lat = ERR_NONE;
      end
    end
  endtask

  // Work out the result of one accepted vertex.
  task automatic place_vertex(input in_item_t it, output out_item_t res);
    longint sx, sy, v, lo, hi;
    if (!basis_valid) begin
      latch_basis();
      basis_valid = 1'b1;
    end
    lo = -(64'sd1 <<< (COORD_BITS - 1));
    hi = (64'sd1 <<< (COORD_BITS - 1)) - 1;
    res = '0;
    if (status_lat == ERR_NONE) begin
      sx = longint'(it.local_x) * scale_lat;
      sy = -longint'(it.local_y) * scale_lat;
      for (int i = 0; i < 3; i++) begin
        v = comp_of(anchor_reg, i) + round_away(right_ax[i] * sx + up_ax[i] * sy, 21);
        if (v < lo) v = lo;
        if (v > hi) v = hi;
        case (i)
          0: res.world_x = v[15:0];
          1: res.world_y = v[15:0];
          default: res.world_z = v[15:0];
        endcase
      end
      res.world_scale = scale_lat[15:0];
    end
    res.tex_u_out = it.tex_u;
    res.tex_v_out = it.tex_v;
    res.basis_error = status_lat;
    res.last_out = it.last_vertex;
    if (it.last_vertex) basis_valid = 1'b0;
  endtask

  // ---------------------------------------------------------------------
  // Register port. A write has a setup and an access phase; the shadow
  // copy is updated alongside, since writes happen only while idle.
  // ---------------------------------------------------------------------
  task automatic write_reg(input logic [2:0] idx, input logic [63:0] val);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= CFG_AW'({idx, 3'b000});
    pwdata <= val;
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      REG_FACE:    face_reg = val[47:0];
      REG_UP:      up_reg = val[47:0];
      REG_ANCHOR:  anchor_reg = val[47:0];
      REG_HWORLD:  hworld_reg = val[15:0];
      REG_HPIXELS: hpix_reg = val[15:0];
      default: ;
    endcase
  endtask

  task automatic write_all(input logic [47:0] f, input logic [47:0] u, input logic [47:0] a,
                           input logic [15:0] hw, input logic [15:0] hp);
    write_reg(REG_FACE, {16'd0, f});
    write_reg(REG_UP, {16'd0, u});
    write_reg(REG_ANCHOR, {16'd0, a});
    write_reg(REG_HWORLD, {48'd0, hw});
    write_reg(REG_HPIXELS, {48'd0, hp});
  endtask

  function automatic in_item_t make_vertex(logic [15:0] x, logic [15:0] y,
                                           logic [15:0] u, logic [15:0] v, bit last);
    in_item_t it;
    it.local_x = x;
    it.local_y = y;
    it.tex_u = u;
    it.tex_v = v;
    it.last_vertex = last;
    return it;
  endfunction

  // A random glyph coordinate: mostly modest sizes, sometimes the full range.
  function automatic logic [15:0] rand_coord();
    if ($urandom_range(0, 3) == 0) return 16'($urandom_range(0, 65535));
    return 16'($signed($urandom_range(0, 4095)) - 2048);
  endfunction

  // A random direction component: often small, sometimes zero or extreme.
  function automatic logic [15:0] rand_dir();
    case ($urandom_range(0, 5))
      0: return 16'd0;
      1: return $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
      2: return 16'($urandom_range(0, 65535));
      default: return 16'($signed($urandom_range(0, 16383)) - 8192);
    endcase
  endfunction

  function automatic logic [15:0] rand_height();
    case ($urandom_range(0, 5))
      0: return 16'd1;
      1: return 16'hFFFF;
      2: return 16'($urandom_range(0, 65535));
      default: return 16'($urandom_range(64, 1024));
    endcase
  endfunction

  // Queue a number of glyph lists of random length with random content.
  task automatic queue_lists(input int count);
    int left, len;
    left = count;
    while (left > 0) begin
      len = $urandom_range(1, 12);
      if (len > left) len = left;
      for (int k = 0; k < len; k++)
        vertex_q.push_back(make_vertex(rand_coord(), rand_coord(),
                                       16'($urandom_range(0, 65535)),
                                       16'($urandom_range(0, 65535)), k == len - 1));
      left -= len;
    end
  endtask

  // Wait until every queued vertex has gone and every result is in.
  task automatic drain();
    while (vertex_q.size() != 0 || in_valid || world_q.size() != 0) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------
  // Sender. A beat, once offered, stays on the bus until it is taken; gaps
  // are inserted at random between beats.
  // ---------------------------------------------------------------------
  int in_gap;
  always @(negedge clk) begin
    if (rst_n && (!in_valid || in_took)) begin
      if (in_gap > 0) begin
        in_gap <= in_gap - 1;
        in_valid <= 1'b0;
      end else if (vertex_q.size() != 0) begin
        in_data <= vertex_q.pop_front();
        in_valid <= 1'b1;
        if (!quiet && $urandom_range(0, 7) == 0) in_gap <= $urandom_range(1, 17);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------
  // Receiver. Random stalls, plus one long hold-off on
  // request so that the input queue fills and in_ready drops.
  // ---------------------------------------------------------------------
  int out_stall;
  always @(negedge clk) begin
    if (out_stall > 0) begin
      out_stall <= out_stall - 1;
      out_ready <= 1'b0;
    end else if (hold_asks != hold_served) begin
      hold_served <= hold_asks;
      out_stall <= 400;
      out_ready <= 1'b0;
    end else if (!quiet && $urandom_range(0, 9) == 0) begin
      out_stall <= $urandom_range(0, 16);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // ---------------------------------------------------------------------
  // Monitor and checker, sampling at the rising edge.
  // ---------------------------------------------------------------------
  always @(posedge clk) begin
    out_item_t exp_res, new_res;
    bit bad;
    in_took = 1'b0;
    if (rst_n) begin
      if (in_valid && in_ready) begin
        in_took = 1'b1;
        place_vertex(in_data, new_res);
        world_q.push_back(new_res);
      end
      if (out_valid && out_ready) begin
        if (world_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("Unexpected result beat %p", out_data);
        end else begin
          exp_res = world_q.pop_front();
          bad = out_data.world_x != exp_res.world_x || out_data.world_y != exp_res.world_y
             || out_data.world_z != exp_res.world_z
             || out_data.tex_u_out != exp_res.tex_u_out
             || out_data.tex_v_out != exp_res.tex_v_out
             || out_data.world_scale != exp_res.world_scale
             || out_data.basis_error != exp_res.basis_error
             || out_data.last_out != exp_res.last_out;
          if (bad) begin
            mismatches++;
            if (mismatches <= 10) $display("Mismatch: expected %p, got %p", exp_res, out_data);
          end
        end
      end
      // Watchdog: any handshake or register access counts as progress.
      if (in_took || (out_valid && out_ready) || psel) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= 20000) begin
        $display("FAIL");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------
  // Stimulus: directed lists first, then random settings and lists.
  // ---------------------------------------------------------------------
  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    out_ready = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    in_gap = 0;
    out_stall = 0;
    hold_asks = 0;
    hold_served = 0;
    quiet = 1'b0;
    mismatches = 0;
    idle_cycles = 0;
    basis_valid = 1'b0;
    face_reg = '0;
    up_reg = '0;
    anchor_reg = '0;
    hworld_reg = HWORLD_RESET;
    hpix_reg = HPIXELS_RESET;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Reset values leave a zero face vector.
    vertex_q.push_back(make_vertex(16'h0010, 16'h0020, 16'h0000, 16'hFFFF, 1'b1));
    drain();
    // Zero up vector.
    write_all({16'd0, 16'd0, 16'd8192}, 48'd0, 48'd0, 16'd256, 16'd256);
    vertex_q.push_back(make_vertex(16'h0100, 16'hFF00, 16'hFFFF, 16'h0000, 1'b1));
    drain();
    // Collinear vectors: up points exactly against the face.
    write_all({16'd0, 16'd4096, 16'd0}, {16'd0, -16'sd8192, 16'd0}, 48'd0, 16'd256, 16'd256);
    vertex_q.push_back(make_vertex(16'h0100, 16'h0100, 16'h1234, 16'h5678, 1'b1));
    drain();
    // A proper basis with field extremes; the list is left open on purpose.
    write_all({16'd8192, 16'd0, 16'd0}, {16'd0, 16'd8192, 16'd0},
              {16'h8000, 16'h7FFF, 16'h0000}, 16'hFFFF, 16'd1);
    vertex_q.push_back(make_vertex(16'h7FFF, 16'h8000, 16'hFFFF, 16'hFFFF, 1'b0));
    vertex_q.push_back(make_vertex(16'h8000, 16'h7FFF, 16'h0000, 16'h0000, 1'b0));
    vertex_q.push_back(make_vertex(16'h0000, 16'h0000, 16'hAAAA, 16'h5555, 1'b0));
    drain();
    // Register writes in the middle of a list only apply to the next list;
    // zero pixel height saturates the scale.
    write_all({16'h7FFF, 16'h8000, 16'h7FFF}, {16'h8000, 16'h7FFF, 16'h0001},
              {16'h0100, 16'hFF00, 16'h7FFF}, 16'd256, 16'd0);
    vertex_q.push_back(make_vertex(16'h0040, 16'hFFC0, 16'h5555, 16'hAAAA, 1'b1));
    vertex_q.push_back(make_vertex(16'h0040, 16'hFFC0, 16'h0001, 16'h8000, 1'b0));
    vertex_q.push_back(make_vertex(16'h8000, 16'h8000, 16'h8000, 16'h0001, 1'b1));
    drain();
    // Zero world height puts every vertex on the anchor.
    write_reg(REG_HWORLD, 64'd0);
    write_reg(REG_HPIXELS, 64'd320);
    vertex_q.push_back(make_vertex(16'h7FFF, 16'h7FFF, 16'h0F0F, 16'hF0F0, 1'b0));
    vertex_q.push_back(make_vertex(16'h8000, 16'h0000, 16'hF0F0, 16'h0F0F, 1'b1));
    drain();

    // Random phases with fresh settings; one phase keeps the receiver
    // stalled for a long stretch while the sender keeps offering beats.
    for (int ph = 0; ph < 13; ph++) begin
      logic [47:0] f, u;
      f = {rand_dir(), rand_dir(), rand_dir()};
      u = {rand_dir(), rand_dir(), rand_dir()};
      if ($urandom_range(0, 9) == 0) u = {f[46:32], 1'b0, f[30:16], 1'b0, f[14:0], 1'b0};
      write_all(f, u, {16'($urandom), 16'($urandom), 16'($urandom)},
                rand_height(), rand_height());
      if (ph == 11) quiet = 1'b1;
      queue_lists(118);
      if (ph == 3) hold_asks = hold_asks + 1;
      drain();
    end

    repeat (20) @(posedge clk);
    if (mismatches == 0 && world_q.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
